// ===== hdl/h2a_pkg.sv =====
`timescale 1ns / 1ps
package h2a_pkg;

  // command codes on the cmd field
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUB  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 3'd5;

  // register reset values
  localparam logic signed [15:0] LOWER_RST = 16'sd0;
  localparam logic [14:0]        WIDTH_RST = 15'd16;
  localparam logic [6:0]         GRID_RST  = 7'd64;

  // coordinate offset width, one quotient bit per divider step
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIV_CNT_W = 4;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic calc_idx;
    logic emit_miss;
    logic emit_hit;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic is_point;
    logic is_read;
    logic pre_ok;
    logic read_ok;
    logic in_grid;
  } status_t;

endpackage

// ===== hdl/h2a_ctrl.sv =====
`timescale 1ns / 1ps
module h2a_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  h2a_pkg::status_t st,
  output h2a_pkg::ctl_t    ctl,
  output logic             busy
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIVIDE,
    ST_INDEX,
    ST_FETCH,
    ST_UPDATE
  } state_t;

  state_t state, state_next;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (st.is_point && st.pre_ok) begin
          state_next = ST_DIVIDE;
        end else if (st.is_read && st.read_ok) begin
          state_next = ST_FETCH;
        end else begin
          ctl.emit_miss = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        ctl.div_step = 1'b1;
        if (st.div_last) state_next = ST_INDEX;
      end
      ST_INDEX: begin
        ctl.calc_idx = 1'b1;
        state_next   = ST_FETCH;
      end
      ST_FETCH: begin
        if (st.is_point && !st.in_grid) begin
          ctl.emit_miss = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctl.emit_hit = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

// ===== hdl/h2a_dpath.sv =====
`timescale 1ns / 1ps
module h2a_dpath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  h2a_pkg::ctl_t                       ctl,
  output h2a_pkg::status_t                    st,
  input  logic                                cfg_wr_en,
  input  logic [h2a_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic [1:0]                          cmd,
  input  logic signed [15:0]                  point_x,
  input  logic signed [15:0]                  point_y,
  input  logic [15:0]                         amount,
  input  logic [11:0]                         read_index,
  output logic                                done,
  output logic                                hit,
  output logic [11:0]                         bin_index,
  output logic signed [31:0]                  bin_count,
  output logic signed [31:0]                  total_count
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // saturating add to a signed 32-bit count
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [16:0] d);
    logic signed [33:0] s;
    s = 34'(a) + 34'(d);
    if (s > 34'sd2147483647) begin
      sat_add = 32'sh7fffffff;
    end else if (s < -34'sd2147483648) begin
      sat_add = 32'sh80000000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // configuration registers
  logic signed [15:0] lower_x, lower_y;
  logic [14:0]        width_x, width_y;
  logic [6:0]         cols_used, rows_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_x   <= h2a_pkg::LOWER_RST;
      lower_y   <= h2a_pkg::LOWER_RST;
      width_x   <= h2a_pkg::WIDTH_RST;
      width_y   <= h2a_pkg::WIDTH_RST;
      cols_used <= h2a_pkg::GRID_RST;
      rows_used <= h2a_pkg::GRID_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        h2a_pkg::CFG_LOWER_X:   lower_x   <= cfg_data;
        h2a_pkg::CFG_LOWER_Y:   lower_y   <= cfg_data;
        h2a_pkg::CFG_WIDTH_X:   width_x   <= cfg_data[14:0];
        h2a_pkg::CFG_WIDTH_Y:   width_y   <= cfg_data[14:0];
        h2a_pkg::CFG_COLS_USED: cols_used <= cfg_data[6:0];
        h2a_pkg::CFG_ROWS_USED: rows_used <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [1:0]  cmd_r;
  logic [15:0] amount_r;
  logic        pre_ok, read_ok, in_grid;

  // offsets from the lower bounds
  logic signed [16:0] off_x, off_y;
  assign off_x = 17'(point_x) - 17'(lower_x);
  assign off_y = 17'(point_y) - 17'(lower_y);

  // restoring dividers, one quotient bit per step for both axes
  logic [h2a_pkg::COORD_W-1:0]   num_x, num_y;
  logic [14:0]                   rem_x, rem_y;
  logic [h2a_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [15:0]                   trial_x, trial_y, diff_x, diff_y;
  logic                          ge_x, ge_y;

  assign trial_x = {rem_x, num_x[h2a_pkg::COORD_W-1]};
  assign trial_y = {rem_y, num_y[h2a_pkg::COORD_W-1]};
  assign ge_x    = trial_x >= {1'b0, width_x};
  assign ge_y    = trial_y >= {1'b0, width_y};
  assign diff_x  = trial_x - {1'b0, width_x};
  assign diff_y  = trial_y - {1'b0, width_y};

  // grid limits, clamped to the store size
  logic [15:0] cols_eff, rows_eff;
  logic [31:0] prod, idx_full;

  assign cols_eff = (16'(cols_used) > 16'(MAX_COLS)) ? 16'(MAX_COLS) : 16'(cols_used);
  assign rows_eff = (16'(rows_used) > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : 16'(rows_used);
  assign prod     = num_y * cols_eff;
  assign idx_full = prod + 32'(num_x);

  // bin store address and clearing sweep
  logic [ADDR_W-1:0] addr, clr_addr;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd;
      amount_r <= amount;
      pre_ok   <= !off_x[16] && !off_y[16] && (width_x != '0) && (width_y != '0);
      read_ok  <= {20'd0, read_index} < 32'(DEPTH);
      addr     <= ADDR_W'(read_index);
      num_x    <= off_x[15:0];
      num_y    <= off_y[15:0];
      rem_x    <= '0;
      rem_y    <= '0;
      div_cnt  <= '0;
    end else if (ctl.div_step) begin
      num_x   <= {num_x[h2a_pkg::COORD_W-2:0], ge_x};
      num_y   <= {num_y[h2a_pkg::COORD_W-2:0], ge_y};
      rem_x   <= ge_x ? diff_x[14:0] : trial_x[14:0];
      rem_y   <= ge_y ? diff_y[14:0] : trial_y[14:0];
      div_cnt <= div_cnt + 1'b1;
    end else if (ctl.calc_idx) begin
      in_grid <= (num_x < cols_eff) && (num_y < rows_eff);
      addr    <= idx_full[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  logic is_point;
  assign is_point = (cmd_r == h2a_pkg::CMD_ADD) || (cmd_r == h2a_pkg::CMD_SUB);

  // status to the controller
  always_comb begin
    st          = '0;
    st.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
    st.div_last = (div_cnt == h2a_pkg::DIV_CNT_W'(h2a_pkg::COORD_W - 1));
    st.is_point = is_point;
    st.is_read  = (cmd_r == h2a_pkg::CMD_READ);
    st.pre_ok   = pre_ok;
    st.read_ok  = read_ok;
    st.in_grid  = in_grid;
  end

  // bin update
  logic signed [31:0] total, rd_data, new_bin, new_total;
  logic signed [16:0] delta;

  assign delta     = (cmd_r == h2a_pkg::CMD_SUB) ? -$signed({1'b0, amount_r})
                                                 : $signed({1'b0, amount_r});
  assign new_bin   = sat_add(rd_data, delta);
  assign new_total = sat_add(total, delta);

  // bin store, registered read
  logic signed [31:0] mem [DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;

  assign mem_we  = ctl.clr_step || (ctl.emit_hit && is_point);
  assign wr_addr = ctl.clr_step ? clr_addr : addr;
  assign wr_data = ctl.clr_step ? 32'sd0 : new_bin;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[addr];
  end

  // running total
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.emit_hit && is_point) begin
      total <= new_total;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit_hit || ctl.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_hit) begin
      hit         <= 1'b1;
      bin_index   <= 12'(addr);
      bin_count   <= is_point ? new_bin : rd_data;
      total_count <= is_point ? new_total : total;
    end else if (ctl.emit_miss) begin
      hit         <= 1'b0;
      bin_index   <= '0;
      bin_count   <= '0;
      total_count <= total;
    end
  end

endmodule

// ===== hdl/histogram_2d_accumulator.sv =====
`timescale 1ns / 1ps
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// item in   | start high, busy low  | cmd, point_x, point_y, amount, read_index
// result    | done strobe, 1 cycle  | hit, bin_index, bin_count, total_count
// config    | cfg_wr_en             | cfg_index, cfg_data
//
// a point that lands in the grid passes decode, the bit-serial dividers, index,
// fetch and update before the next item can be accepted; a read passes decode,
// fetch and update, a point rejected on its bounds or widths ends in decode, one
// outside the grid ends in fetch; the bin store's registered read puts a fetch
// state before each update; after reset the bin store is swept to zero with busy
// high; results cannot be held off, done marks each for exactly one cycle
module histogram_2d_accumulator #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic [15:0]                   amount,
  input  logic [11:0]                   read_index,
  input  logic                          cfg_wr_en,
  input  logic [h2a_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          done,
  output logic                          hit,
  output logic [11:0]                   bin_index,
  output logic signed [31:0]            bin_count,
  output logic signed [31:0]            total_count
);

  h2a_pkg::ctl_t    ctl;
  h2a_pkg::status_t st;

  // sequencer
  h2a_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  // dividers, bin store and totals
  h2a_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .point_x     (point_x),
    .point_y     (point_y),
    .amount      (amount),
    .read_index  (read_index),
    .done        (done),
    .hit         (hit),
    .bin_index   (bin_index),
    .bin_count   (bin_count),
    .total_count (total_count)
  );

endmodule

// ===== hdl/h2a_checker.sv =====
`timescale 1ns / 1ps
module h2a_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               hit,
  input logic [11:0]        bin_index,
  input logic signed [31:0] bin_count
);

  // a result strobe is never held high
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a missed item reports no bin
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (bin_index == '0 && bin_count == '0))
    else $error("missed item carries a bin");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

endmodule

bind histogram_2d_accumulator h2a_checker u_h2a_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .hit       (hit),
  .bin_index (bin_index),
  .bin_count (bin_count)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int         GRID_MAX  = 64;
  localparam int         STORE_N   = 4096;
  localparam longint     CNT_HI    = 2147483647;
  localparam longint     CNT_LO    = -CNT_HI - 1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic [15:0]         amt;
    logic [11:0]         ridx;
  } point_cmd_t;

  typedef struct packed {
    logic                hit;
    logic [11:0]         idx;
    logic signed [31:0]  cnt;
    logic signed [31:0]  tot;
  } bin_result_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [1:0]                     cmd;
  logic signed [15:0]             point_x;
  logic signed [15:0]             point_y;
  logic [15:0]                    amount;
  logic [11:0]                    read_index;
  logic                           cfg_wr_en;
  logic [h2a_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]                    cfg_data;
  logic                           done;
  logic                           hit;
  logic [11:0]                    bin_index;
  logic signed [31:0]             bin_count;
  logic signed [31:0]             total_count;

  // grid setting and histogram contents as the block should hold them
  logic signed [15:0]    g_lx;
  logic signed [15:0]    g_ly;
  logic [14:0]           g_wx;
  logic [14:0]           g_wy;
  logic [6:0]            g_cols;
  logic [6:0]            g_rows;
  logic signed [31:0]    count_mirror [STORE_N];
  logic signed [31:0]    total_mirror;

  point_cmd_t            cmd_queue [$];
  bin_result_t           expected_bins [$];
  point_cmd_t            in_flight;
  bit                    gap_free;
  int                    items_taken;
  int                    results_seen;
  int                    hits_seen;
  int                    mismatches;
  int                    grids_loaded;

  histogram_2d_accumulator DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .point_x     (point_x),
    .point_y     (point_y),
    .amount      (amount),
    .read_index  (read_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .hit         (hit),
    .bin_index   (bin_index),
    .bin_count   (bin_count),
    .total_count (total_count)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // add with clamping at the signed 32-bit limits
  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint d);
    longint s;
    s = longint'(a) + d;
    if (s > CNT_HI) s = CNT_HI;
    if (s < CNT_LO) s = CNT_LO;
    return 32'(s);
  endfunction

  // apply one item to the mirrored histogram and give the result it should produce
  function automatic bin_result_t bin_update(point_cmd_t p);
    bin_result_t res;
    int          ec;
    int          er;
    int          col;
    int          row;
    longint      delta;
    res = '0;
    ec = (g_cols > GRID_MAX) ? GRID_MAX : int'(g_cols);
    er = (g_rows > GRID_MAX) ? GRID_MAX : int'(g_rows);
    if (p.cmd == h2a_pkg::CMD_ADD || p.cmd == h2a_pkg::CMD_SUB) begin
      if (int'(p.x) >= int'(g_lx) && int'(p.y) >= int'(g_ly) && g_wx != 0 && g_wy != 0) begin
        col = (int'(p.x) - int'(g_lx)) / int'(g_wx);
        row = (int'(p.y) - int'(g_ly)) / int'(g_wy);
        if (col < ec && row < er) begin
          delta = (p.cmd == h2a_pkg::CMD_ADD) ? longint'(p.amt) : -longint'(p.amt);
          res.idx = 12'(row * ec + col);
          count_mirror[res.idx] = clamp_add(count_mirror[res.idx], delta);
          total_mirror = clamp_add(total_mirror, delta);
          res.cnt = count_mirror[res.idx];
          res.hit = 1'b1;
        end
      end
    end else if (p.cmd == h2a_pkg::CMD_READ) begin
      res.hit = 1'b1;
      res.idx = p.ridx;
      res.cnt = count_mirror[p.ridx];
    end
    res.tot = total_mirror;
    return res;
  endfunction

  // driver: present queued items, hold each until the block takes it
  always @(posedge clk) begin : feed
    point_cmd_t nxt;
    if (!rst) begin
      if (start && !busy) begin
        expected_bins.insert(expected_bins.size(), bin_update(in_flight));
        items_taken++;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && (gap_free || $urandom_range(0, 99) >= 14)) begin
          nxt = cmd_queue.pop_front();
          in_flight = nxt;
          start <= 1'b1;
          cmd <= nxt.cmd;
          point_x <= nxt.x;
          point_y <= nxt.y;
          amount <= nxt.amt;
          read_index <= nxt.ridx;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check each strobed result against the oldest prediction
  always @(posedge clk) begin : observe
    bin_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit %0d bin %0d count %0d total %0d",
                   hit, bin_index, bin_count, total_count);
      end else begin
        want = expected_bins.pop_front();
        if (want.hit) hits_seen++;
        if (hit !== want.hit || bin_index !== want.idx || bin_count !== want.cnt ||
            total_count !== want.tot) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected hit %0d bin %0d count %0d total %0d",
                     want.hit, want.idx, want.cnt, want.tot);
            $display("          got      hit %0d bin %0d count %0d total %0d",
                     hit, bin_index, bin_count, total_count);
          end
        end
      end
    end
  end

  // queue one item
  task automatic queue_cmd(input logic [1:0] c, input int x, input int y, input int a,
                           input int ri);
    point_cmd_t p;
    p.cmd = c;
    p.x = 16'(x);
    p.y = 16'(y);
    p.amt = 16'(a);
    p.ridx = 12'(ri);
    cmd_queue.insert(cmd_queue.size(), p);
  endtask

  // wait until every item is taken and answered and the block is quiet
  task automatic drain();
    while (cmd_queue.size() != 0 || start || expected_bins.size() != 0 || busy)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // write all six grid registers, one per clock
  task automatic program_grid(input int lx, input int ly, input int wx, input int wy,
                              input int nc, input int nr);
    logic [h2a_pkg::CFG_IDX_W-1:0] regs [6];
    logic [15:0]                   vals [6];
    int                            i;
    regs = '{h2a_pkg::CFG_LOWER_X, h2a_pkg::CFG_LOWER_Y, h2a_pkg::CFG_WIDTH_X,
             h2a_pkg::CFG_WIDTH_Y, h2a_pkg::CFG_COLS_USED, h2a_pkg::CFG_ROWS_USED};
    vals = '{16'(lx), 16'(ly), 16'(wx), 16'(wy), 16'(nc), 16'(nr)};
    for (i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    g_lx = 16'(lx);
    g_ly = 16'(ly);
    g_wx = 15'(wx);
    g_wy = 15'(wy);
    g_cols = 7'(nc);
    g_rows = 7'(nr);
    grids_loaded++;
  endtask

  // random item: mostly points aimed into the grid, some reads, edges and noise
  function automatic point_cmd_t random_cmd();
    point_cmd_t p;
    int         ec;
    int         er;
    int         wx;
    int         wy;
    int         roll;
    int         c;
    int         r;
    int         x;
    int         y;
    ec = (g_cols > GRID_MAX) ? GRID_MAX : int'(g_cols);
    er = (g_rows > GRID_MAX) ? GRID_MAX : int'(g_rows);
    wx = int'(g_wx);
    wy = int'(g_wy);
    roll = $urandom_range(0, 99);
    p.cmd = $urandom_range(0, 1) ? h2a_pkg::CMD_ADD : h2a_pkg::CMD_SUB;
    p.x = 16'($urandom);
    p.y = 16'($urandom);
    p.amt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    p.ridx = 12'($urandom);
    if (roll < 10) begin
      // noise: any command code, any point
      p.cmd = 2'($urandom);
    end else if (roll < 25) begin
      // read, mostly of a bin inside the grid
      p.cmd = h2a_pkg::CMD_READ;
      if (roll < 20) p.ridx = 12'($urandom_range(0, ec * er - 1));
    end else begin
      c = $urandom_range(0, ec - 1);
      r = $urandom_range(0, er - 1);
      // just past the far edge of the grid
      if (roll < 28) c = ec;
      else if (roll < 30) r = er;
      x = int'(g_lx) + c * wx + int'($urandom_range(0, wx - 1));
      y = int'(g_ly) + r * wy + int'($urandom_range(0, wy - 1));
      // just under a lower bound
      if (roll >= 30 && roll < 32) x = int'(g_lx) - 1 - int'($urandom_range(0, 31));
      else if (roll >= 32 && roll < 34) y = int'(g_ly) - 1 - int'($urandom_range(0, 31));
      if (x >= -32768 && x <= 32767) p.x = 16'(x);
      if (y >= -32768 && y <= 32767) p.y = 16'(y);
    end
    return p;
  endfunction

  // stimulus
  initial begin
    int     ph;
    int     nc;
    int     nr;
    rst = 1'b1;
    start = 1'b0;
    cmd = h2a_pkg::CMD_ADD;
    point_x = '0;
    point_y = '0;
    amount = '0;
    read_index = '0;
    cfg_wr_en = 1'b0;
    cfg_index = h2a_pkg::CFG_LOWER_X;
    cfg_data = '0;
    gap_free = 1'b0;
    g_lx = h2a_pkg::LOWER_RST;
    g_ly = h2a_pkg::LOWER_RST;
    g_wx = h2a_pkg::WIDTH_RST;
    g_wy = h2a_pkg::WIDTH_RST;
    g_cols = h2a_pkg::GRID_RST;
    g_rows = h2a_pkg::GRID_RST;
    foreach (count_mirror[i]) count_mirror[i] = '0;
    total_mirror = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset grid: corners, zero amount, rejects, unused code, reads
    queue_cmd(h2a_pkg::CMD_ADD, 0, 0, 1, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 1023, 1023, 65535, 0);
    queue_cmd(h2a_pkg::CMD_SUB, 1023, 1023, 65535, 0);
    queue_cmd(h2a_pkg::CMD_SUB, 16, 0, 300, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 5, 17, 0, 0);
    queue_cmd(h2a_pkg::CMD_ADD, -1, 0, 5, 0);
    queue_cmd(h2a_pkg::CMD_SUB, 0, -32768, 5, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 1024, 0, 7, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 0, 1024, 7, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 32767, 32767, 65535, 0);
    queue_cmd(CMD_SPARE, 0, 0, 9, 0);
    queue_cmd(h2a_pkg::CMD_READ, 0, 0, 0, 0);
    queue_cmd(h2a_pkg::CMD_READ, 0, 0, 0, 4095);
    queue_cmd(h2a_pkg::CMD_READ, -1, -1, 65535, 2730);

    // widest bins from the lowest bound
    drain();
    program_grid(-32768, -32768, 32767, 32767, 64, 64);
    queue_cmd(h2a_pkg::CMD_ADD, -32768, -32768, 1000, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 32767, 32767, 65535, 0);
    queue_cmd(h2a_pkg::CMD_SUB, -1, -1, 2, 0);
    queue_cmd(h2a_pkg::CMD_READ, 0, 0, 0, 130);

    // one narrow bin at the top bound
    drain();
    program_grid(32767, 32767, 1, 1, 1, 1);
    queue_cmd(h2a_pkg::CMD_ADD, 32767, 32767, 4, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 32766, 32767, 4, 0);

    // zero width or zero grid size rejects every point
    drain();
    program_grid(0, 0, 0, 16, 64, 64);
    queue_cmd(h2a_pkg::CMD_ADD, 0, 0, 3, 0);
    drain();
    program_grid(0, 0, 16, 0, 64, 64);
    queue_cmd(h2a_pkg::CMD_ADD, 0, 0, 3, 0);
    drain();
    program_grid(0, 0, 16, 16, 0, 64);
    queue_cmd(h2a_pkg::CMD_ADD, 0, 0, 3, 0);
    drain();
    program_grid(0, 0, 16, 16, 64, 0);
    queue_cmd(h2a_pkg::CMD_SUB, 0, 0, 3, 0);

    // oversize grid acts as the largest one
    drain();
    program_grid(0, 0, 16, 16, 127, 100);
    queue_cmd(h2a_pkg::CMD_ADD, 1023, 16, 77, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 1100, 0, 77, 0);
    queue_cmd(h2a_pkg::CMD_READ, 0, 0, 0, 127);

    // random grids, one phase without gaps
    for (ph = 0; ph < 8; ph++) begin
      drain();
      nc = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      nr = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      program_grid(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                   $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 200),
                   $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 200),
                   nc, nr);
      gap_free = (ph == 3);
      repeat (125) cmd_queue.insert(cmd_queue.size(), random_cmd());
    end

    // full-scale weights piled onto one bin, then taken back and read
    drain();
    gap_free = 1'b0;
    program_grid(0, 0, 16, 16, 4, 4);
    repeat (30) queue_cmd(h2a_pkg::CMD_ADD, 3, 2, 65535, 0);
    queue_cmd(h2a_pkg::CMD_SUB, 3, 2, 65535, 0);
    queue_cmd(h2a_pkg::CMD_ADD, 3, 2, 65535, 0);
    queue_cmd(h2a_pkg::CMD_READ, 0, 0, 0, 0);

    drain();
    $display("run covered %0d items over %0d grid settings, %0d results of which %0d hits,",
             items_taken, grids_loaded, results_seen, hits_seen);
    $display("including edge and reject cases and full-scale weights on one bin; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("timed out with %0d items queued and %0d results outstanding",
             cmd_queue.size(), expected_bins.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
